/* hw/rtl/stt_pkg.sv */
// Shared types, codes and helpers for the software timer table.
package stt_pkg;

  // Input item codes
  localparam logic [1:0] MODE_CREATE_PERIODIC = 2'd0;
  localparam logic [1:0] MODE_CREATE_ONESHOT  = 2'd1;
  localparam logic [1:0] MODE_DESTROY         = 2'd2;
  localparam logic [1:0] MODE_SERVICE         = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_CREATED   = 3'd0;
  localparam logic [2:0] KIND_FULL      = 3'd1;
  localparam logic [2:0] KIND_DESTROYED = 3'd2;
  localparam logic [2:0] KIND_FIRED     = 3'd3;
  localparam logic [2:0] KIND_WAIT      = 3'd4;

  // Configuration register indexes
  localparam logic REG_MIN_WAIT = 1'b0;
  localparam logic REG_MAX_WAIT = 1'b1;

  localparam logic [31:0] MIN_WAIT_RST = 32'd1000;
  localparam logic [31:0] MAX_WAIT_RST = 32'd100000;

  // Interval storage width and ms to us factor
  localparam int          INTERVAL_W = 42;
  localparam logic [9:0]  MS_TO_US   = 10'd1000;

  // floor(x / 1000) == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
  localparam logic [28:0] RECIP_1000  = 29'd274877907;
  localparam int          RECIP_SHIFT = 38;
  localparam int          PROD_W      = 61;
  localparam int          WAIT_W      = 23;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] interval_ms;
    logic [4:0]  slot;
    logic [63:0] now_us;
  } stt_in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [4:0]  slot_id;
    logic [22:0] wait_ms;
    logic        last;
  } stt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CREATE,
    ST_DESTROY,
    ST_SCAN,
    ST_DIFF,
    ST_CLAMP,
    ST_DIV,
    ST_REPORT
  } stt_state_e;

  // 64-bit add that saturates at the largest value
  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

/* hw/rtl/software_timer_table.sv */
// Software timer table: slot valid flags in flops, intervals and deadlines in two RAMs.
// Create and destroy: the result is registered once the output is free, next transfer after it.
// Service: a scan with one read of both RAMs per slot through a two-stage pipe, then
// difference, clamp, divide-by-1000 and report: the wait report comes last, and the next
// transfer is accepted after it; output stalls hold the scan and the report.
// Reset empties the table and loads the wait clamps with 1000 us and 100000 us.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int TIMER_SLOTS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  stt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output stt_out_t out_data_o,
  input  logic     cfg_we_i,
  input  logic     cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(TIMER_SLOTS);

  stt_state_e state_q, state_d;

  stt_in_t                 in_q;
  logic [INTERVAL_W-1:0]   ius_q;
  logic [TIMER_SLOTS-1:0]  valid_q, valid_d;
  logic [31:0]             min_q, max_q;

  // scan pipeline
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic             s1_v_q, s1_v_d;
  logic [IDX_W-1:0] s1_idx_q, s1_idx_d;
  logic             s2_v_q, s2_v_d;
  logic [IDX_W-1:0] s2_idx_q, s2_idx_d;
  logic             s2_fire_q, s2_fire_d;
  logic             s2_rearm_q, s2_rearm_d;
  logic             s2_keep_q, s2_keep_d;
  logic [63:0]      s2_dl_q, s2_dl_d;
  logic             adv;

  // wait computation
  logic [63:0]       nearest_q, nearest_d;
  logic [63:0]       diff_q, diff_d;
  logic [31:0]       clamp_q, clamp_d;
  logic [PROD_W-1:0] prod_q, prod_d;

  // output register
  logic     out_valid_q, out_valid_d;
  stt_out_t out_q, out_d;
  logic     out_free;

  // RAM ports
  logic                  int_we, dl_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [INTERVAL_W-1:0] int_wdata, int_rdata;
  logic [63:0]           dl_wdata, dl_rdata;

  // lowest free slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic in_acc;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  stt_ram #(.WIDTH(INTERVAL_W), .DEPTH(TIMER_SLOTS)) u_interval_ram (
    .clk_i   (clk_i),
    .we_i    (int_we),
    .waddr_i (ram_waddr),
    .wdata_i (int_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (int_rdata)
  );

  stt_ram #(.WIDTH(64), .DEPTH(TIMER_SLOTS)) u_deadline_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (ram_waddr),
    .wdata_i (dl_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (dl_rdata)
  );

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Per-slot evaluation on the RAM read data
  always_comb begin
    logic vbit;
    logic zero_int;
    vbit       = valid_q[s1_idx_q];
    zero_int   = (int_rdata == '0);
    s2_idx_d   = s1_idx_q;
    s2_fire_d  = vbit && (in_q.now_us >= dl_rdata);
    s2_rearm_d = s2_fire_d && !zero_int;
    s2_keep_d  = vbit && !(s2_fire_d && zero_int);
    s2_dl_d    = s2_fire_d ? sat_add64(in_q.now_us, 64'(int_rdata)) : dl_rdata;
  end

  // Scan holds while a fired result cannot be placed
  assign adv = !(s2_v_q && s2_fire_q && !out_free);

  // Sequencer: next state, RAM control, output load
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    rd_idx_d    = rd_idx_q;
    s1_v_d      = s1_v_q;
    s1_idx_d    = s1_idx_q;
    s2_v_d      = s2_v_q;
    nearest_d   = nearest_q;
    diff_d      = diff_q;
    clamp_d     = clamp_q;
    prod_d      = prod_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    int_we      = 1'b0;
    dl_we       = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    int_wdata   = '0;
    dl_wdata    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_data_i.mode)
            MODE_CREATE_PERIODIC, MODE_CREATE_ONESHOT: state_d = ST_CREATE;
            MODE_DESTROY: state_d = ST_DESTROY;
            MODE_SERVICE: begin
              state_d   = ST_SCAN;
              rd_idx_d  = '0;
              nearest_d = '1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_CREATE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{result_kind: KIND_FULL, slot_id: '0, wait_ms: '0, last: 1'b1};
          if (free_found) begin
            int_we    = 1'b1;
            dl_we     = 1'b1;
            ram_waddr = free_idx;
            int_wdata = (in_q.mode == MODE_CREATE_PERIODIC) ? ius_q : '0;
            dl_wdata  = sat_add64(in_q.now_us, 64'(ius_q));
            valid_d[free_idx] = 1'b1;
            out_d.result_kind = KIND_CREATED;
            out_d.slot_id     = 5'(free_idx);
          end
          state_d = ST_IDLE;
        end
      end

      ST_DESTROY: begin
        if (out_free) begin
          if (7'(in_q.slot) < 7'(TIMER_SLOTS)) begin
            valid_d[IDX_W'(in_q.slot)] = 1'b0;
          end
          out_valid_d = 1'b1;
          out_d = '{result_kind: KIND_DESTROYED, slot_id: in_q.slot, wait_ms: '0, last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      ST_SCAN: begin
        if (adv) begin
          // read stage
          if (rd_idx_q < SLOT_CNT) begin
            ram_re    = 1'b1;
            ram_raddr = rd_idx_q[IDX_W-1:0];
            rd_idx_d  = rd_idx_q + 1'b1;
            s1_v_d    = 1'b1;
            s1_idx_d  = rd_idx_q[IDX_W-1:0];
          end else begin
            s1_v_d = 1'b0;
          end
          s2_v_d = s1_v_q;
          // update stage
          if (s2_v_q) begin
            if (s2_rearm_q) begin
              dl_we     = 1'b1;
              ram_waddr = s2_idx_q;
              dl_wdata  = s2_dl_q;
            end else if (s2_fire_q) begin
              valid_d[s2_idx_q] = 1'b0;
            end
            if (s2_keep_q && (s2_dl_q < nearest_q)) begin
              nearest_d = s2_dl_q;
            end
            if (s2_fire_q) begin
              out_valid_d = 1'b1;
              out_d = '{result_kind: KIND_FIRED, slot_id: 5'(s2_idx_q), wait_ms: '0,
                        last: 1'b0};
            end
          end
          if (!s1_v_q && !s2_v_q && (rd_idx_q == SLOT_CNT)) begin
            state_d = ST_DIFF;
          end
        end
      end

      ST_DIFF: begin
        diff_d  = (nearest_q > in_q.now_us) ? (nearest_q - in_q.now_us) : '0;
        state_d = ST_CLAMP;
      end

      ST_CLAMP: begin
        // lower clamp checked first; if the clamps cross, values at or above it get the upper clamp
        priority if (diff_q < {32'b0, min_q}) begin
          clamp_d = min_q;
        end else if (diff_q > {32'b0, max_q}) begin
          clamp_d = max_q;
        end else begin
          clamp_d = diff_q[31:0];
        end
        state_d = ST_DIV;
      end

      ST_DIV: begin
        prod_d  = {29'b0, clamp_q} * {32'b0, RECIP_1000};
        state_d = ST_REPORT;
      end

      ST_REPORT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{result_kind: KIND_WAIT, slot_id: '0,
                    wait_ms: prod_q[RECIP_SHIFT +: WAIT_W], last: 1'b1};
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      rd_idx_q    <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= MIN_WAIT_RST;
      max_q       <= MAX_WAIT_RST;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_idx_q    <= rd_idx_d;
      s1_v_q      <= s1_v_d;
      s2_v_q      <= s2_v_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_MIN_WAIT: min_q <= cfg_wdata_i;
          REG_MAX_WAIT: max_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q  <= in_data_i;
      ius_q <= INTERVAL_W'(in_data_i.interval_ms) * INTERVAL_W'(MS_TO_US);
    end
    s1_idx_q  <= s1_idx_d;
    if (state_q == ST_SCAN && adv) begin
      s2_idx_q   <= s2_idx_d;
      s2_fire_q  <= s2_fire_d;
      s2_rearm_q <= s2_rearm_d;
      s2_keep_q  <= s2_keep_d;
      s2_dl_q    <= s2_dl_d;
    end
    nearest_q <= nearest_d;
    diff_q    <= diff_d;
    clamp_q   <= clamp_d;
    prod_q    <= prod_d;
    out_q     <= out_d;
  end

  // Scan pipeline is empty whenever no item is in work
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !s1_v_q && !s2_v_q)
    else $error("scan pipeline busy while idle");

  // Read counter never passes the table size
  a_rd_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= SLOT_CNT)
    else $error("scan read index out of range");

  // A re-arm write never lands on the slot being read
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dl_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("deadline write collides with read");

endmodule

/* hw/rtl/stt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* tb/sv/tb_software_timer_table.sv */
// Self-checking testbench for the software timer table: directed and random traffic checked against a predictor.
module tb_software_timer_table
  import stt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS        = 32;
  localparam int STALL_LIMIT  = 3000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [63:0] T0  = 64'd1_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  stt_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  stt_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = REG_MIN_WAIT;
  logic [31:0] cfg_wdata_i = '0;

  software_timer_table #(
    .TIMER_SLOTS(SLOTS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Timer table mirror and wait clamps
  logic        tbl_valid [SLOTS];
  logic [41:0] tbl_ival [SLOTS];
  logic [63:0] tbl_deadline [SLOTS];
  logic [31:0] clamp_min = MIN_WAIT_RST;
  logic [31:0] clamp_max = MAX_WAIT_RST;

  stt_in_t  ops_q[$];
  stt_out_t results_due_q[$];

  logic [63:0] clock_us;
  int err_count = 0;
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_requests = 0;
  int holds_done = 0;
  int send_gap = 0;
  int recv_wait = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  bit drv_valid;

  initial begin
    for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
  end

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
  endfunction

  // Apply one operation to the mirror and queue the results it should produce
  function automatic void step_timer_table(stt_in_t op);
    stt_out_t    res;
    logic [41:0] ius;
    logic [63:0] nearest;
    logic [63:0] span;
    bit          placed;
    res = '0;
    res.last = 1'b1;
    case (op.mode)
      MODE_CREATE_PERIODIC, MODE_CREATE_ONESHOT: begin
        ius = 42'(64'(op.interval_ms) * 64'd1000);
        placed = 1'b0;
        res.result_kind = KIND_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!placed && !tbl_valid[i]) begin
            placed = 1'b1;
            tbl_valid[i] = 1'b1;
            tbl_deadline[i] = sum_sat(op.now_us, 64'(ius));
            tbl_ival[i] = (op.mode == MODE_CREATE_PERIODIC) ? ius : '0;
            res.result_kind = KIND_CREATED;
            res.slot_id = 5'(i);
          end
        end
        results_due_q.push_back(res);
      end
      MODE_DESTROY: begin
        if (int'(op.slot) < SLOTS) tbl_valid[op.slot] = 1'b0;
        res.result_kind = KIND_DESTROYED;
        res.slot_id = op.slot;
        results_due_q.push_back(res);
      end
      default: begin
        // scan in slot order; now stays fixed for the whole pass
        nearest = 64'hFFFF_FFFF_FFFF_FFFF;
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_valid[i]) begin
            if (op.now_us >= tbl_deadline[i]) begin
              res = '0;
              res.result_kind = KIND_FIRED;
              res.slot_id = 5'(i);
              results_due_q.push_back(res);
              if (tbl_ival[i] != '0) tbl_deadline[i] = sum_sat(op.now_us, 64'(tbl_ival[i]));
              else tbl_valid[i] = 1'b0;
            end
            if (tbl_valid[i] && tbl_deadline[i] < nearest) nearest = tbl_deadline[i];
          end
        end
        span = (nearest > op.now_us) ? nearest - op.now_us : 64'd0;
        // lower clamp checked first; if the clamps cross, spans at or above it get the upper clamp
        if (span < 64'(clamp_min)) span = 64'(clamp_min);
        else if (span > 64'(clamp_max)) span = 64'(clamp_max);
        res = '0;
        res.result_kind = KIND_WAIT;
        res.wait_ms = 23'(span / 64'd1000);
        res.last = 1'b1;
        results_due_q.push_back(res);
      end
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_count < 30) $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  task automatic check_result(stt_out_t got);
    stt_out_t want;
    if (results_due_q.size() == 0) begin
      flag_mismatch("result with nothing pending", got, '0);
      return;
    end
    want = results_due_q.pop_front();
    if (got.result_kind !== want.result_kind)
      flag_mismatch("result_kind", 32'(got.result_kind), 32'(want.result_kind));
    if (got.slot_id !== want.slot_id)
      flag_mismatch("slot_id", 32'(got.slot_id), 32'(want.slot_id));
    if (got.wait_ms !== want.wait_ms)
      flag_mismatch("wait_ms", 32'(got.wait_ms), 32'(want.wait_ms));
    if (got.last !== want.last)
      flag_mismatch("last", 32'(got.last), 32'(want.last));
  endtask

  function automatic void add_op(logic [1:0] mode, logic [31:0] ims, logic [4:0] sl,
                                 logic [63:0] now);
    stt_in_t op;
    op.mode = mode;
    op.interval_ms = ims;
    op.slot = sl;
    op.now_us = now;
    ops_q.push_back(op);
  endfunction

  // Mostly a coherent timeline of creates, destroys and services, some noise
  function automatic void add_random_ops(int count);
    int          pick;
    int          sz;
    logic [31:0] ims;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      sz = $urandom_range(0, 9);
      ims = (sz == 0) ? 32'd0 : (sz < 8) ? 32'($urandom_range(1, 200)) : $urandom();
      if (pick < 35) begin
        clock_us += (pick < 4) ? 64'($urandom_range(0, 2_000_000))
                               : 64'($urandom_range(0, 120_000));
        add_op(MODE_SERVICE, $urandom(), 5'($urandom()), clock_us);
      end else if (pick < 65) begin
        add_op((pick % 2 == 1) ? MODE_CREATE_ONESHOT : MODE_CREATE_PERIODIC, ims,
               5'($urandom()), clock_us);
      end else if (pick < 85) begin
        add_op(MODE_DESTROY, $urandom(), 5'($urandom()), clock_us);
      end else begin
        add_op(2'($urandom()), $urandom(), 5'($urandom()), {$urandom(), $urandom()});
      end
    end
  endfunction

  task automatic settle();
    while (ops_q.size() != 0 || drv_valid || results_due_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MIN_WAIT) clamp_min = val;
    else clamp_max = val;
  endtask

  // Input driver: one item per transfer, random gap after each while send_idle is set
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      drv_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        step_timer_table(in_data_i);
        drv_valid = 1'b0;
      end
      if (!drv_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (ops_q.size() > 0) begin
          in_data_i <= ops_q.pop_front();
          drv_valid = 1'b1;
          send_gap = send_idle ? $urandom_range(0, 10) : 0;
        end
      end
      in_valid_i <= drv_valid;
    end
  end

  // Result monitor with random stall and the long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_result(out_data_o);
        recv_wait = recv_idle ? $urandom_range(0, 10) : 0;
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      if (holds_done != hold_requests) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (recv_wait > 0) || (hold_left > 0);
    end
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, zero and max intervals, saturation, fire order, destroys
    add_op(MODE_SERVICE, 32'd0, 5'd0, 64'd0);
    add_op(MODE_CREATE_PERIODIC, 32'd5, 5'd0, T0);
    add_op(MODE_CREATE_ONESHOT, 32'd2, 5'd0, T0);
    add_op(MODE_CREATE_PERIODIC, 32'd0, 5'd0, T0);
    add_op(MODE_CREATE_ONESHOT, 32'hFFFF_FFFF, 5'h1F, T0);
    add_op(MODE_CREATE_PERIODIC, 32'd7, 5'd0, 64'hFFFF_FFFF_FFFF_FF00);
    add_op(MODE_SERVICE, 32'd0, 5'd0, T0);
    add_op(MODE_SERVICE, 32'd0, 5'd0, T0 + 64'd2000);
    add_op(MODE_SERVICE, 32'd0, 5'd0, T0 + 64'd5000);
    add_op(MODE_DESTROY, 32'd0, 5'd31, 64'd0);
    add_op(MODE_DESTROY, 32'd0, 5'd3, 64'd0);
    add_op(MODE_DESTROY, 32'd0, 5'd0, 64'd0);
    add_op(MODE_SERVICE, 32'd0, 5'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(MODE_DESTROY, 32'hFFFF_FFFF, 5'd4, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(MODE_CREATE_ONESHOT, 32'd0, 5'd0, 64'd0);
    add_op(MODE_SERVICE, 32'd0, 5'd0, T0);
    add_op(MODE_CREATE_PERIODIC, 32'd150, 5'd0, T0);
    add_op(MODE_SERVICE, 32'd0, 5'd0, T0);
    add_op(MODE_SERVICE, 32'hFFFF_FFFF, 5'h1F, T0 + 64'd150_000);
    settle();
    clock_us = T0 + 64'd200_000;

    // Widest clamps, sender without gaps
    write_reg(REG_MIN_WAIT, 32'd0);
    write_reg(REG_MAX_WAIT, 32'hFFFF_FFFF);
    send_idle = 1'b0;
    add_random_ops(45);
    settle();

    // Crossed clamps; fill the table while the receiver holds off
    write_reg(REG_MIN_WAIT, 32'd50_000);
    write_reg(REG_MAX_WAIT, 32'd2000);
    recv_idle = 1'b0;
    hold_requests++;
    for (int k = 0; k < 34; k++)
      add_op((k % 3 == 0) ? MODE_CREATE_ONESHOT : MODE_CREATE_PERIODIC,
             32'($urandom_range(50, 400)), 5'($urandom()), clock_us);
    for (int k = 0; k < 6; k++) begin
      clock_us += 64'($urandom_range(20_000, 150_000));
      add_op(MODE_SERVICE, $urandom(), 5'($urandom()), clock_us);
    end
    add_random_ops(10);
    settle();

    // Zero clamps, both sides idling
    write_reg(REG_MIN_WAIT, 32'd0);
    write_reg(REG_MAX_WAIT, 32'd0);
    send_idle = 1'b1;
    recv_idle = 1'b1;
    add_random_ops(45);
    settle();

    // Both clamps at the top
    write_reg(REG_MIN_WAIT, 32'hFFFF_FFFF);
    write_reg(REG_MAX_WAIT, 32'hFFFF_FFFF);
    recv_idle = 1'b0;
    add_random_ops(40);
    settle();

    // Random clamps
    write_reg(REG_MIN_WAIT, 32'($urandom_range(0, 20_000)));
    write_reg(REG_MAX_WAIT, 32'($urandom_range(0, 300_000)));
    recv_idle = 1'b1;
    add_random_ops(40);

    while (ops_q.size() != 0 || drv_valid || results_due_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (results_due_q.size() != 0)
      flag_mismatch("results never seen", 32'(results_due_q.size()), 32'd0);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* software_timer_table.f */
hw/rtl/stt_pkg.sv
hw/rtl/stt_ram.sv
hw/rtl/software_timer_table.sv
tb/sv/tb_software_timer_table.sv
